/* design/keyed_fifo_pool_unit_assert.svh */
// Assertion macros for the keyed FIFO pool checker.
// Used by kfp_checker.sv; no other dependencies.
`ifndef KEYED_FIFO_POOL_UNIT_ASSERT_SVH
`define KEYED_FIFO_POOL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kfp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kfp check failed");

`endif

/* design/kfp_pkg.sv */
// Shared types and constants for the keyed FIFO pool.
// No dependencies.
package kfp_pkg;

    localparam int DEF_POOL_DEPTH    = 64;
    localparam int DEF_PAYLOAD_WIDTH = 64;
    localparam int OPCODE_W          = 3;
    localparam int KEY_W             = 32;
    localparam int FIELD_PAYLOAD_W   = 64;
    localparam int STATUS_W          = 2;
    localparam int OCC_W             = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_TAKE_FIRST = 3'd1,
        OP_TAKE_KEY   = 3'd2,
        OP_PEEK_KEY   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_NOP        = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Classified request as it travels from front to back.
    typedef struct packed {
        t_op                        op;
        logic [KEY_W-1:0]           key;
        logic [FIELD_PAYLOAD_W-1:0] data;
    } t_cmd;

endpackage

/* design/kfp_if.sv */
// Valid/ready channel interfaces for request and response.
// Depends on kfp_pkg.
interface kfp_req_if import kfp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [KEY_W-1:0]           key_ref;
    logic [FIELD_PAYLOAD_W-1:0] payload;

    modport source (output valid, opcode, key_ref, payload, input ready);
    modport sink   (input valid, opcode, key_ref, payload, output ready);
endinterface

interface kfp_rsp_if import kfp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [KEY_W-1:0]           out_ref;
    logic [FIELD_PAYLOAD_W-1:0] out_payload;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, status, out_ref, out_payload, occupancy, input ready);
    modport sink   (input valid, status, out_ref, out_payload, occupancy, output ready);
endinterface

/* design/keyed_fifo_pool_unit.sv */
// Keyed FIFO pool top level: front decode, two-entry queue, back end.
// Depends on kfp_pkg, kfp_if, kfp_front, kfp_queue, kfp_back.
//
//  channel | dir | handshake           | payload
//  i_req   | in  | valid/ready         | opcode, key_ref, payload
//  o_rsp   | out | valid/ready         | status, out_ref, out_payload, occupancy
//
// Simple ops (append, take first, clear, unknown): response registered in the cycle after
//   the back end pops the request; next pop only once it is taken.
// Take/peek by key: full rotation of the cell ring in S_SCAN, then S_FIN registers the
//   response; next pop only once it is taken.
// Requests queue (two deep) while a response waits on o_rsp.ready.
// Reset is synchronous, active low; pool empty after reset, no clearing pass.
module keyed_fifo_pool_unit import kfp_pkg::*; #(
    parameter int POOL_DEPTH    = DEF_POOL_DEPTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kfp_req_if.sink   i_req,
    kfp_rsp_if.source o_rsp
);

    logic q_full;
    logic push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    kfp_front #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    kfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    kfp_back #(
        .POOL_DEPTH    (POOL_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_rsp       (o_rsp)
    );

endmodule

/* design/kfp_front.sv */
// Front end: takes requests, decodes the opcode and trims the payload.
// Depends on kfp_pkg and kfp_if.
module kfp_front import kfp_pkg::*; #(
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    kfp_req_if.sink i_req,
    input  logic    i_q_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    localparam logic [FIELD_PAYLOAD_W-1:0] DATA_MASK =
        {FIELD_PAYLOAD_W{1'b1}} >> (FIELD_PAYLOAD_W - PAYLOAD_WIDTH);

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    always_comb begin
        case (i_req.opcode)
            OP_APPEND:     o_cmd.op = OP_APPEND;
            OP_TAKE_FIRST: o_cmd.op = OP_TAKE_FIRST;
            OP_TAKE_KEY:   o_cmd.op = OP_TAKE_KEY;
            OP_PEEK_KEY:   o_cmd.op = OP_PEEK_KEY;
            OP_CLEAR:      o_cmd.op = OP_CLEAR;
            default:       o_cmd.op = OP_NOP;
        endcase
        o_cmd.key  = i_req.key_ref;
        o_cmd.data = i_req.payload & DATA_MASK;
    end

endmodule

/* design/kfp_queue.sv */
// Two-entry queue between front and back.
// Depends on kfp_pkg.
module kfp_queue import kfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* design/kfp_back.sv */
// Back end: the entry cells, the scan sequencer and the response register.
// Depends on kfp_pkg and kfp_if.
module kfp_back import kfp_pkg::*; #(
    parameter int POOL_DEPTH    = DEF_POOL_DEPTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    kfp_rsp_if.source o_rsp
);

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int IW = $clog2(POOL_DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(POOL_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;
    typedef enum logic [1:0] {CA_HOLD, CA_WRITE, CA_SHIFT, CA_ROTATE} t_cell_act;

    logic [KEY_W-1:0]         r_key  [POOL_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_data [POOL_DEPTH];

    t_state                   r_state,    n_state;
    logic [CW-1:0]            r_count,    n_count;
    logic [IW-1:0]            r_t,        n_t;
    logic [IW-1:0]            r_idx,      n_idx;
    logic                     r_found,    n_found;
    logic                     r_take,     n_take;
    logic [KEY_W-1:0]         r_skey,     n_skey;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_status,   n_status;
    logic [KEY_W-1:0]         r_out_ref,  n_out_ref;
    logic [PAYLOAD_WIDTH-1:0] r_out_data, n_out_data;

    t_cell_act                cell_act;
    logic [IW-1:0]            shift_idx;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_t         = r_t;
        n_idx       = r_idx;
        n_found     = r_found;
        n_take      = r_take;
        n_skey      = r_skey;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_ref   = r_out_ref;
        n_out_data  = r_out_data;
        o_cmd_pop   = 1'b0;
        cell_act    = CA_HOLD;
        shift_idx   = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out_ref   = '0;
                    n_out_data  = '0;
                    case (i_cmd.op)
                        OP_APPEND: begin
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_act = CA_WRITE;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_TAKE_FIRST: begin
                            if (r_count == '0) begin
                                n_status = ST_MISS;
                            end else begin
                                n_out_ref  = r_key[0];
                                n_out_data = r_data[0];
                                cell_act   = CA_SHIFT;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        OP_TAKE_KEY, OP_PEEK_KEY: begin
                            if (r_count == '0) begin
                                n_status = ST_MISS;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_t         = '0;
                                n_found     = 1'b0;
                                n_take      = (i_cmd.op == OP_TAKE_KEY);
                                n_skey      = i_cmd.key;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // full ring rotation: cell 0 shows entry r_t, order restored at the end
                cell_act = CA_ROTATE;
                if (!r_found && (CW'(r_t) < r_count) && (r_key[0] == r_skey)) begin
                    n_found    = 1'b1;
                    n_idx      = r_t;
                    n_out_data = r_data[0];
                end
                n_t = r_t + 1'b1;
                if (r_t == LAST_IDX) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_found) begin
                    n_status  = ST_OK;
                    n_out_ref = r_skey;
                    if (r_take) begin
                        cell_act  = CA_SHIFT;
                        shift_idx = r_idx;
                        n_count   = r_count - 1'b1;
                    end
                end else begin
                    n_status   = ST_MISS;
                    n_out_ref  = '0;
                    n_out_data = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_cell
        always_ff @(posedge i_clk) begin
            case (cell_act)
                CA_WRITE: begin
                    if (CW'(j) == r_count) begin
                        r_key[j]  <= i_cmd.key;
                        r_data[j] <= i_cmd.data[PAYLOAD_WIDTH-1:0];
                    end
                end
                CA_SHIFT: begin
                    if ((j < POOL_DEPTH - 1) && (IW'(j) >= shift_idx)) begin
                        r_key[j]  <= r_key[(j + 1) % POOL_DEPTH];
                        r_data[j] <= r_data[(j + 1) % POOL_DEPTH];
                    end
                end
                CA_ROTATE: begin
                    r_key[j]  <= r_key[(j + 1) % POOL_DEPTH];
                    r_data[j] <= r_data[(j + 1) % POOL_DEPTH];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_t        <= n_t;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_take     <= n_take;
        r_skey     <= n_skey;
        r_status   <= n_status;
        r_out_ref  <= n_out_ref;
        r_out_data <= n_out_data;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_ref     = r_out_ref;
    assign o_rsp.out_payload = FIELD_PAYLOAD_W'(r_out_data);
    assign o_rsp.occupancy   = OCC_W'(r_count);

endmodule

/* design/kfp_checker.sv */
// Port-level checks for the keyed FIFO pool, bound to the top level.
// Depends on kfp_pkg and keyed_fifo_pool_unit_assert.svh.
`include "keyed_fifo_pool_unit_assert.svh"

module kfp_checker import kfp_pkg::*; #(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [STATUS_W-1:0]        i_status,
    input logic [KEY_W-1:0]           i_out_ref,
    input logic [FIELD_PAYLOAD_W-1:0] i_out_payload,
    input logic [OCC_W-1:0]           i_occupancy
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(POOL_DEPTH);

    `KFP_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `KFP_ASSERT_NOW(a_full_drop, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_FULL), (i_occupancy == OCC_FULL) && (i_out_ref == '0) && (i_out_payload == '0))
    `KFP_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_MISS), (i_out_ref == '0) && (i_out_payload == '0))

endmodule

bind keyed_fifo_pool_unit kfp_checker #(.POOL_DEPTH(POOL_DEPTH)) u_kfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_out_ref     (o_rsp.out_ref),
    .i_out_payload (o_rsp.out_payload),
    .i_occupancy   (o_rsp.occupancy)
);
